/* design/ioct_pkg.sv */
// ----------------------------------------------------------------------------
// ioct_pkg
// Shared constants, command and status types for the occurrence count table.
// ----------------------------------------------------------------------------
package ioct_pkg;

  localparam int unsigned OpcodeW = 2;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned KindW   = 2;

  // Input command codes.
  localparam logic [OpcodeW-1:0] OP_COUNT   = 2'd0;
  localparam logic [OpcodeW-1:0] OP_QUERY   = 2'd1;
  localparam logic [OpcodeW-1:0] OP_DUMP    = 2'd2;
  localparam logic [OpcodeW-1:0] OP_UNKNOWN = 2'd3;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_QUERY = 2'd0;
  localparam logic [KindW-1:0] KIND_DUMP  = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR = 2'd2;
  localparam logic [KindW-1:0] KIND_FULL  = 2'd3;

  // Controller to datapath.
  typedef struct packed {
    logic             capture;    // input beat taken, register compare flags
    logic             commit;     // apply count: increment or insert
    logic             load;       // load the output register
    logic [KindW-1:0] kind;       // kind of the loaded result
    logic             dump_step;  // advance the dump pointer
  } ioct_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [OpcodeW-1:0] op;
    logic               hit;
    logic               full;
    logic               empty;
    logic               dump_last;
    logic               out_free;
  } ioct_sts_t;

  // Table order: fourth octet first, then the first, second and third.
  function automatic logic [AddrW-1:0] order_key(input logic [AddrW-1:0] a);
    return {a[7:0], a[31:8]};
  endfunction

endpackage

/* design/ioct_ctrl.sv */
// ----------------------------------------------------------------------------
// ioct_ctrl
// Sequencer for the occurrence count table: takes a command, applies it and
// walks the table during a dump.
// ----------------------------------------------------------------------------
module ioct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ioct_pkg::ioct_sts_t sts_i,
  output ioct_pkg::ioct_cmd_t cmd_o
);
  import ioct_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_DUMP   = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d            = state_q;
    in_ready_o         = 1'b0;
    cmd_o              = '0;
    cmd_o.kind         = KIND_QUERY;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        case (sts_i.op)
          OP_COUNT: begin
            if (sts_i.hit || !sts_i.full) begin
              cmd_o.commit = 1'b1;
              state_d      = ST_IDLE;
            end else if (sts_i.out_free) begin
              cmd_o.load = 1'b1;
              cmd_o.kind = KIND_FULL;
              state_d    = ST_IDLE;
            end
          end
          OP_QUERY: begin
            if (sts_i.out_free) begin
              cmd_o.load = 1'b1;
              cmd_o.kind = KIND_QUERY;
              state_d    = ST_IDLE;
            end
          end
          OP_DUMP: begin
            state_d = sts_i.empty ? ST_IDLE : ST_DUMP;
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.load = 1'b1;
              cmd_o.kind = KIND_ERROR;
              state_d    = ST_IDLE;
            end
          end
        endcase
      end
      ST_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.kind      = KIND_DUMP;
          cmd_o.dump_step = 1'b1;
          if (sts_i.dump_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/ioct_dp.sv */
// ----------------------------------------------------------------------------
// ioct_dp
// Sorted cell chain with parallel compare, insert by shifting, the dump
// pointer and the output register.
// ----------------------------------------------------------------------------
module ioct_dp #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ioct_pkg::OpcodeW-1:0]  in_opcode_i,
  input  logic [ioct_pkg::AddrW-1:0]    in_address_i,
  input  ioct_pkg::ioct_cmd_t           cmd_i,
  output ioct_pkg::ioct_sts_t           sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ioct_pkg::KindW-1:0]    out_kind_o,
  output logic [ioct_pkg::AddrW-1:0]    out_address_o,
  output logic [ioct_pkg::CountW-1:0]   out_count_o,
  output logic                          out_last_o
);
  import ioct_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [AddrW-1:0]       key_q [TABLE_DEPTH];
  logic [CountW-1:0]      cnt_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [TABLE_DEPTH-1:0] lt_q, lt_d;
  logic [TABLE_DEPTH-1:0] eq_q, eq_d;
  logic [OpcodeW-1:0]     op_q;
  logic [AddrW-1:0]       addr_q;
  logic [IdxW-1:0]        idx_q;
  logic [TABLE_DEPTH-1:0] next_valid;
  logic [CountW-1:0]      hit_cnt;
  logic                   hit;
  logic                   insert;

  logic                   out_valid_q;
  logic [KindW-1:0]       out_kind_q;
  logic [AddrW-1:0]       out_addr_q;
  logic [CountW-1:0]      out_cnt_q;
  logic                   out_last_q;

  // Every cell compares its key with the incoming address in parallel.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      lt_d[i] = valid_q[i] && (order_key(key_q[i]) < order_key(in_address_i));
      eq_d[i] = valid_q[i] && (key_q[i] == in_address_i);
    end
  end

  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_cnt = hit_cnt | (eq_q[i] ? cnt_q[i] : '0);
    end
  end

  assign hit        = |eq_q;
  assign insert     = cmd_i.commit && !hit;
  assign next_valid = valid_q >> 1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lt_q   <= lt_d;
      eq_q   <= eq_d;
      op_q   <= in_opcode_i;
      addr_q <= in_address_i;
    end
  end

  // Cells below the insert point keep their place; the rest move up by one.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic at_pos;
    logic shift;
    if (i == 0) begin : g_head
      assign at_pos = !lt_q[0];
      assign shift  = 1'b0;
    end else begin : g_body
      assign at_pos = !lt_q[i] && lt_q[i-1];
      assign shift  = !lt_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (insert && at_pos) begin
        key_q[i] <= addr_q;
        cnt_q[i] <= CountW'(1);
      end else if (insert && shift) begin
        if (i > 0) begin
          key_q[i] <= key_q[(i > 0) ? i - 1 : 0];
          cnt_q[i] <= cnt_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.commit && eq_q[i] && (cnt_q[i] != '1)) begin
        cnt_q[i] <= cnt_q[i] + CountW'(1);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (insert && at_pos) begin
        valid_q[i] <= 1'b1;
      end else if (insert && shift) begin
        valid_q[i] <= valid_q[(i > 0) ? i - 1 : 0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.capture) begin
      idx_q <= '0;
    end else if (cmd_i.dump_step) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_kind_q <= cmd_i.kind;
      case (cmd_i.kind)
        KIND_QUERY: begin
          out_addr_q <= addr_q;
          out_cnt_q  <= hit_cnt;
          out_last_q <= 1'b1;
        end
        KIND_DUMP: begin
          out_addr_q <= key_q[idx_q];
          out_cnt_q  <= cnt_q[idx_q];
          out_last_q <= !next_valid[idx_q];
        end
        KIND_FULL: begin
          out_addr_q <= addr_q;
          out_cnt_q  <= '0;
          out_last_q <= 1'b1;
        end
        default: begin
          out_addr_q <= '0;
          out_cnt_q  <= '0;
          out_last_q <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.op        = op_q;
    sts_o.hit       = hit;
    sts_o.full      = valid_q[TABLE_DEPTH-1];
    sts_o.empty     = !valid_q[0];
    sts_o.dump_last = !next_valid[idx_q];
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_address_o = out_addr_q;
  assign out_count_o   = out_cnt_q;
  assign out_last_o    = out_last_q;

endmodule

/* design/ipv4_occurrence_count_table_top.sv */
// ----------------------------------------------------------------------------
// ipv4_occurrence_count_table_top
// Sorted table of IPv4 addresses with saturating occurrence counts.
// ----------------------------------------------------------------------------
// Count, query and unknown commands are handled per beat by first accepting
// it and comparing against every cell, then updating the cell chain or
// loading the result. A dump sends one entry per cycle out of the single
// output register while it is free. Reset is asynchronous, active low,
// and empties the table by clearing the cell valid bits.
module ipv4_occurrence_count_table_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] address
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] entry_address, [63:32] entry_count
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);
  import ioct_pkg::*;

  ioct_cmd_t         cmd;
  ioct_sts_t         sts;
  logic [AddrW-1:0]  out_address;
  logic [CountW-1:0] out_count;

  ioct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ioct_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_opcode_i   (s_axis_tuser),
    .in_address_i  (s_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_kind_o    (m_axis_tuser),
    .out_address_o (out_address),
    .out_count_o   (out_count),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {out_count, out_address};

endmodule

/* tb/ipv4_occurrence_count_table_top_test.sv */
// ----------------------------------------------------------------------------
// ipv4_occurrence_count_table_top_test
// Self-checking bench for the sorted IPv4 occurrence count table. A short
// directed run covers the empty dump, unknown commands, extreme addresses
// and key order; random traffic then fills the table past its depth, with
// both stream sides stalling at random in two of its three phases. Every
// result beat is compared with a prediction kept in a small table model.
// ----------------------------------------------------------------------------
module ipv4_occurrence_count_table_top_test;
  import ioct_pkg::*;

  localparam int unsigned Depth       = 32;
  localparam int unsigned RandomItems = 144;
  localparam int unsigned PoolSize    = 40;
  localparam int unsigned DrainCycles = Depth + 8;
  localparam int unsigned CycleLimit  = 400000;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [AddrW-1:0]  addr;
    logic [CountW-1:0] count;
    logic              last;
  } table_result_t;

  // Sorted copy of the table plus the queue of results still owed.
  class occurrence_table_model;
    logic [AddrW-1:0]  keys [Depth];
    logic [CountW-1:0] counts [Depth];
    int unsigned       used = 0;
    table_result_t     owed [$];
    int unsigned       mismatches = 0;
    int unsigned       beats_seen = 0;

    // Order: fourth octet, then the first, second and third.
    function logic [AddrW-1:0] key_of(input logic [AddrW-1:0] a);
      return {a[7:0], a[31:24], a[23:16], a[15:8]};
    endfunction

    function table_result_t make_result(input logic [KindW-1:0] kind,
                                        input logic [AddrW-1:0] addr,
                                        input logic [CountW-1:0] count,
                                        input logic last);
      table_result_t r;
      r.kind  = kind;
      r.addr  = addr;
      r.count = count;
      r.last  = last;
      return r;
    endfunction

    function void add_owed(input table_result_t r);
      owed = {owed, r};
    endfunction

    function void accept_command(input logic [OpcodeW-1:0] op,
                                 input logic [AddrW-1:0] addr);
      int unsigned pos;
      bit hit;
      pos = 0;
      while (pos < used && key_of(keys[pos]) < key_of(addr)) pos++;
      hit = (pos < used) && (keys[pos] == addr);
      case (op)
        OP_COUNT: begin
          if (hit) begin
            if (counts[pos] != '1) counts[pos]++;
          end else if (used == Depth) begin
            add_owed(make_result(KIND_FULL, addr, '0, 1'b1));
          end else begin
            for (int j = used; j > pos; j--) begin
              keys[j]   = keys[j-1];
              counts[j] = counts[j-1];
            end
            keys[pos]   = addr;
            counts[pos] = 1;
            used++;
          end
        end
        OP_QUERY: begin
          add_owed(make_result(KIND_QUERY, addr, hit ? counts[pos] : '0, 1'b1));
        end
        OP_DUMP: begin
          for (int j = 0; j < used; j++)
            add_owed(make_result(KIND_DUMP, keys[j], counts[j], j + 1 == used));
        end
        default: begin
          add_owed(make_result(KIND_ERROR, '0, '0, 1'b1));
        end
      endcase
    endfunction

    function void check_result(input logic [KindW-1:0] kind,
                               input logic [AddrW-1:0] addr,
                               input logic [CountW-1:0] count,
                               input logic last);
      table_result_t got;
      table_result_t want;
      got = make_result(kind, addr, count, last);
      beats_seen++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d: none expected, got kind %0d addr %h count %h last %b",
                   beats_seen, got.kind, got.addr, got.count, got.last);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("beat %0d: expected kind %0d addr %h count %h last %b",
                   beats_seen, want.kind, want.addr, want.count, want.last);
          $display("beat %0d: got kind %0d addr %h count %h last %b",
                   beats_seen, got.kind, got.addr, got.count, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] address
  logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [31:0] entry_address, [63:32] entry_count
  logic [1:0]  m_axis_tuser;        // [1:0] kind
  logic        m_axis_tlast;

  occurrence_table_model model = new;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  logic [AddrW-1:0] addr_pool [PoolSize];

  ipv4_occurrence_count_table_top #(
    .TABLE_DEPTH(Depth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      model.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                         m_axis_tlast);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_command(input logic [OpcodeW-1:0] op,
                              input logic [AddrW-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    model.accept_command(op, addr);
  endtask

  function automatic logic [OpcodeW-1:0] pick_opcode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return OP_COUNT;
    if (r < 80) return OP_QUERY;
    if (r < 90) return OP_DUMP;
    return OP_UNKNOWN;
  endfunction

  // Mostly pool addresses so counts repeat and queries hit.
  function automatic logic [AddrW-1:0] pick_address();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return addr_pool[$urandom_range(PoolSize-1)];
    if (r < 9) return $urandom;
    return $urandom_range(1) ? '1 : '0;
  endfunction

  initial begin
    // Neighboring pool entries share octets so that ties in the leading
    // key byte are resolved by the lower ones.
    for (int i = 0; i < PoolSize; i++) begin
      addr_pool[i] = $urandom;
      if (i % 2 == 1) addr_pool[i][7:0] = addr_pool[i-1][7:0];
      if (i % 4 == 3) addr_pool[i][31:24] = addr_pool[i-1][31:24];
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(OP_DUMP, 32'h0000_0000);
    send_command(OP_QUERY, 32'h0000_0000);
    send_command(OP_UNKNOWN, 32'hFFFF_FFFF);
    send_command(OP_COUNT, 32'h0000_0000);
    send_command(OP_COUNT, 32'hFFFF_FFFF);
    send_command(OP_COUNT, 32'hFFFF_FFFF);
    send_command(OP_COUNT, 32'h0102_03FF);
    send_command(OP_COUNT, 32'hFF00_0000);
    send_command(OP_COUNT, 32'h0A0B_0C05);
    send_command(OP_COUNT, 32'h0A0B_0D05);
    send_command(OP_QUERY, 32'hFFFF_FFFF);
    send_command(OP_QUERY, 32'h0000_0000);
    send_command(OP_QUERY, 32'h1234_5678);
    send_command(OP_DUMP, 32'hFFFF_FFFF);
    send_command(OP_UNKNOWN, 32'h5A5A_5A5A);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 31 : 0;
      repeat (RandomItems / 3) send_command(pick_opcode(), pick_address());
    end
    s_axis_tvalid <= 1'b0;

    while (model.owed.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (model.mismatches == 0 && model.owed.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
